// ===== rtl/core/rsi_pkg.sv =====
// Shared types and constants for the ray/sphere intersection core.
`default_nettype none
package rsi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIST_WIDTH  = COORD_WIDTH - 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t                origin_x;
		coord_t                origin_y;
		coord_t                origin_z;
		coord_t                dir_x;
		coord_t                dir_y;
		coord_t                dir_z;
		coord_t                center_x;
		coord_t                center_y;
		coord_t                center_z;
		logic [DIST_WIDTH-1:0] sphere_radius;
	} ray_t;

	typedef struct packed {
		logic                  hit;
		logic [DIST_WIDTH-1:0] distance;
	} isect_t;

endpackage
`default_nettype wire

// ===== rtl/core/ray_sphere_intersect.sv =====
// Ray against sphere intersection: a deep fixed-point pipeline.
// Each transfer on req carries one ray (origin, direction of any length) and one sphere
// (centre, radius), all fixed point with FRAC_BITS fraction bits. The core forms
// a = D.D, h = oc.D and k = oc.oc - r^2 exactly, takes the floor square root of h^2 - a*k,
// and returns the nearer root if it quantizes to a positive distance, else the farther one,
// else a miss (hit = 0, distance = 0); a zero direction is a miss and a distance beyond the
// field saturates to its maximum with hit = 1. One ray enters every cycle while the skid
// register is empty; the pipeline holds square root stages (one root bit each) and divider
// stages (one quotient bit each).
// The result side has an output register plus a skid register, so req stays ready while a
// result waits on rsp, until the skid register fills.
`default_nettype none
module ray_sphere_intersect #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire rsi_pkg::ray_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output rsi_pkg::isect_t     rsp_data
);
	localparam int W    = rsi_pkg::COORD_WIDTH;
	localparam int DW   = rsi_pkg::DIST_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int OCW  = W + 1;
	localparam int SW   = 2 * W + 4;
	localparam int AUW  = 2 * W;
	localparam int QUW  = 4 * W + 2;
	localparam int RW   = QUW / 2;
	localparam int NW   = 2 * W + 3;
	localparam int NUW  = NW - 1;
	localparam int NNW  = NUW + F;
	localparam int HIW  = NNW - DW;
	localparam int CMW  = (HIW > AUW) ? HIW : AUW;
	localparam int SBW  = 1 + SW + AUW;

	logic adv;

	// stage 1: origin relative to centre
	logic                   v_s1;
	logic signed [OCW-1:0]  oc_s1 [3];
	logic signed [W-1:0]    d_s1  [3];
	logic signed [W-1:0]    r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			oc_s1[0] <= OCW'(req_data.origin_x) - OCW'(req_data.center_x);
			oc_s1[1] <= OCW'(req_data.origin_y) - OCW'(req_data.center_y);
			oc_s1[2] <= OCW'(req_data.origin_z) - OCW'(req_data.center_z);
			d_s1[0]  <= req_data.dir_x;
			d_s1[1]  <= req_data.dir_y;
			d_s1[2]  <= req_data.dir_z;
			r_s1     <= $signed({1'b0, req_data.sphere_radius});
		end
	end

	// stages 2 and 3: component products
	logic signed [2*W-1:0] dd_p [3];
	logic signed [2*W:0]   od_p [3];
	logic signed [2*W+1:0] oo_p [3];
	logic signed [2*W-1:0] rr_p;

	for (genvar i = 0; i < 3; i++) begin : g_comp
		rsi_mul #(.AW(W), .BW(W)) u_dd (
			.clk(clk), .en(adv), .a(d_s1[i]), .b(d_s1[i]), .p(dd_p[i])
		);
		rsi_mul #(.AW(OCW), .BW(W)) u_od (
			.clk(clk), .en(adv), .a(oc_s1[i]), .b(d_s1[i]), .p(od_p[i])
		);
		rsi_mul #(.AW(OCW), .BW(OCW)) u_oo (
			.clk(clk), .en(adv), .a(oc_s1[i]), .b(oc_s1[i]), .p(oo_p[i])
		);
	end

	rsi_mul #(.AW(W), .BW(W)) u_rr (
		.clk(clk), .en(adv), .a(r_s1), .b(r_s1), .p(rr_p)
	);

	// stage 4: quadratic coefficients
	logic signed [SW-1:0] a_s4;
	logic signed [SW-1:0] h_s4;
	logic signed [SW-1:0] k_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4 <= SW'(dd_p[0]) + SW'(dd_p[1]) + SW'(dd_p[2]);
			h_s4 <= SW'(od_p[0]) + SW'(od_p[1]) + SW'(od_p[2]);
			k_s4 <= SW'(oo_p[0]) + SW'(oo_p[1]) + SW'(oo_p[2]) - SW'(rr_p);
		end
	end

	// stages 5 and 6: h^2 and a*k
	logic signed [2*SW-1:0] hh_p;
	logic signed [2*SW-1:0] ak_p;
	logic signed [2*SW-1:0] q_full;
	logic signed [SW-1:0]   h_s5;
	logic signed [SW-1:0]   h_s6;
	logic [AUW-1:0]         a_s5;
	logic [AUW-1:0]         a_s6;

	rsi_mul #(.AW(SW), .BW(SW)) u_hh (
		.clk(clk), .en(adv), .a(h_s4), .b(h_s4), .p(hh_p)
	);
	rsi_mul #(.AW(SW), .BW(SW)) u_ak (
		.clk(clk), .en(adv), .a(a_s4), .b(k_s4), .p(ak_p)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s5 <= h_s4;
			h_s6 <= h_s5;
			a_s5 <= a_s4[AUW-1:0];
			a_s6 <= a_s5;
		end
	end

	// stage 7: quarter discriminant
	logic                   v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [QUW-1:0]         q_s7;
	logic                   miss_s7;
	logic signed [SW-1:0]   h_s7;
	logic [AUW-1:0]         a_s7;

	assign q_full = hh_p - ak_p;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s7    <= q_full[2*SW-1] ? '0 : q_full[QUW-1:0];
			miss_s7 <= q_full[2*SW-1] | (a_s6 == '0);
			h_s7    <= h_s6;
			a_s7    <= a_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// square root of the discriminant, a and h ride along
	logic                 sq_v;
	logic [RW-1:0]        sq_root;
	logic [SBW-1:0]       sq_sb;
	logic                 sq_miss;
	logic signed [SW-1:0] sq_h;
	logic [AUW-1:0]       sq_a;

	rsi_sqrt #(.QW(QUW), .SBW(SBW)) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s7),
		.q(q_s7),
		.in_sb({miss_s7, h_s7, a_s7}),
		.out_valid(sq_v),
		.root(sq_root),
		.out_sb(sq_sb)
	);

	assign sq_miss = sq_sb[SBW-1];
	assign sq_h    = sq_sb[SBW-2 -: SW];
	assign sq_a    = sq_sb[AUW-1:0];

	// stage 8: root numerators
	logic signed [NW-1:0] hx;
	logic signed [NW-1:0] sx;
	logic                 v_s8;
	logic signed [NW-1:0] n0_s8;
	logic signed [NW-1:0] n1_s8;
	logic                 miss_s8;
	logic [AUW-1:0]       a_s8;

	assign hx = NW'(sq_h);
	assign sx = NW'($signed({1'b0, sq_root}));

	always_ff @(posedge clk) begin
		if (adv) begin
			n0_s8   <= -hx - sx;
			n1_s8   <= sx - hx;
			miss_s8 <= sq_miss;
			a_s8    <= sq_a;
		end
	end

	// stage 9: pick the nearest root whose distance is at least one LSB
	logic [NUW-1:0] m0;
	logic [NUW-1:0] m1;
	logic           ok0;
	logic           ok1;
	logic           v_s9;
	logic           hit_s9;
	logic [NUW-1:0] nsel_s9;
	logic [AUW-1:0] a_s9;

	assign m0  = n0_s8[NUW-1:0];
	assign m1  = n1_s8[NUW-1:0];
	assign ok0 = !n0_s8[NW-1] && (n0_s8 != '0) && ((NNW'(m0) << F) >= NNW'(a_s8));
	assign ok1 = !n1_s8[NW-1] && (n1_s8 != '0) && ((NNW'(m1) << F) >= NNW'(a_s8));

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s9  <= !miss_s8 && (ok0 || ok1);
			nsel_s9 <= ok0 ? m0 : m1;
			a_s9    <= a_s8;
		end
	end

	// stage 10: saturation check and divider setup
	logic [NNW-1:0] nn;
	logic [HIW-1:0] nn_hi;
	logic           v_s10;
	logic           hit_s10;
	logic           sat_s10;
	logic [AUW-1:0] rem_s10;
	logic [DW-1:0]  lo_s10;
	logic [AUW-1:0] a_s10;

	assign nn    = NNW'(nsel_s9) << F;
	assign nn_hi = nn[NNW-1:DW];

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s10 <= hit_s9;
			sat_s10 <= (CMW'(nn_hi) >= CMW'(a_s9));
			rem_s10 <= AUW'(nn_hi);
			lo_s10  <= nn[DW-1:0];
			a_s10   <= a_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s8  <= sq_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// restoring divider, one quotient bit per stage
	logic           dv_s   [DW];
	logic [AUW-1:0] drem_s [DW];
	logic [DW-1:0]  dlo_s  [DW];
	logic [DW-1:0]  dquo_s [DW];
	logic           dhit_s [DW];
	logic           dsat_s [DW];
	logic [AUW-1:0] da_s   [DW];

	for (genvar j = 0; j < DW; j++) begin : g_div
		logic           v_in;
		logic [AUW-1:0] rem_in;
		logic [DW-1:0]  lo_in;
		logic [DW-1:0]  quo_in;
		logic           hit_in;
		logic           sat_in;
		logic [AUW-1:0] a_in;
		logic [AUW:0]   t;
		logic           ge;

		if (j == 0) begin : g_first
			assign v_in   = v_s10;
			assign rem_in = rem_s10;
			assign lo_in  = lo_s10;
			assign quo_in = '0;
			assign hit_in = hit_s10;
			assign sat_in = sat_s10;
			assign a_in   = a_s10;
		end else begin : g_next
			assign v_in   = dv_s[j-1];
			assign rem_in = drem_s[j-1];
			assign lo_in  = dlo_s[j-1];
			assign quo_in = dquo_s[j-1];
			assign hit_in = dhit_s[j-1];
			assign sat_in = dsat_s[j-1];
			assign a_in   = da_s[j-1];
		end

		assign t  = {rem_in, lo_in[DW-1]};
		assign ge = (t >= {1'b0, a_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (adv) begin
				dv_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				drem_s[j] <= ge ? AUW'(t - {1'b0, a_in}) : AUW'(t);
				dlo_s[j]  <= {lo_in[DW-2:0], 1'b0};
				dquo_s[j] <= {quo_in[DW-2:0], ge};
				dhit_s[j] <= hit_in;
				dsat_s[j] <= sat_in;
				da_s[j]   <= a_in;
			end
		end
	end

	// result formation, output register and skid register
	logic            pv;
	rsi_pkg::isect_t pd;
	logic            ov_q;
	logic            sv_q;
	rsi_pkg::isect_t od_q;
	rsi_pkg::isect_t sd_q;

	always_comb begin
		pv       = dv_s[DW-1];
		pd.hit   = dhit_s[DW-1];
		if (!dhit_s[DW-1]) begin
			pd.distance = '0;
		end else if (dsat_s[DW-1]) begin
			pd.distance = '1;
		end else begin
			pd.distance = dquo_s[DW-1];
		end
	end

	assign adv       = !sv_q;
	assign req_ready = adv;
	assign rsp_valid = ov_q;
	assign rsp_data  = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			// drain the skid register into the output register
			if (rsp_ready) begin
				sv_q <= 1'b0;
			end
		end else if (ov_q && !rsp_ready) begin
			// hold the output, park a new result in the skid register
			if (pv) begin
				sv_q <= 1'b1;
			end
		end else begin
			ov_q <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (rsp_ready) begin
				od_q <= sd_q;
			end
		end else if (ov_q && !rsp_ready) begin
			if (pv) begin
				sd_q <= pd;
			end
		end else begin
			od_q <= pd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rsi_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none
module rsi_mul #(
	parameter int AW = 33,
	parameter int BW = 32
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [AW-1:0]  a,
	input  wire logic signed [BW-1:0]  b,
	output logic signed [AW+BW-1:0]    p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic        [AL-1:0]    a_lo;
	logic signed [AH-1:0]    a_hi;
	logic        [BL-1:0]    b_lo;
	logic signed [BH-1:0]    b_hi;
	logic        [AL+BL-1:0] ll_s1;
	logic signed [AL+BH:0]   lh_s1;
	logic signed [AH+BL:0]   hl_s1;
	logic signed [AH+BH-1:0] hh_s1;
	logic signed [PW-1:0]    p_s2;

	assign a_lo = a[AL-1:0];
	assign a_hi = a[AW-1:AL];
	assign b_lo = b[BL-1:0];
	assign b_hi = b[BW-1:BL];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a_lo * b_lo;
			lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
			hl_s1 <= a_hi * $signed({1'b0, b_lo});
			hh_s1 <= a_hi * b_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'($signed({1'b0, ll_s1}))
				+ (PW'(lh_s1) << BL)
				+ (PW'(hl_s1) << AL)
				+ (PW'(hh_s1) << (AL + BL));
		end
	end

	assign p = p_s2;

endmodule
`default_nettype wire

// ===== rtl/core/rsi_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a sideband.
`default_nettype none
module rsi_sqrt #(
	parameter int QW  = 130,
	parameter int SBW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [QW-1:0]     q,
	input  wire logic [SBW-1:0]    in_sb,
	output logic                   out_valid,
	output logic [QW/2-1:0]        root,
	output logic [SBW-1:0]         out_sb
);
	localparam int RW  = QW / 2;
	localparam int RMW = RW + 2;
	localparam int TW  = RMW + 2;

	logic           v_s    [RW];
	logic [RMW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [QW-1:0]  rad_s  [RW];
	logic [SBW-1:0] sb_s   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic           v_in;
		logic [RMW-1:0] rem_in;
		logic [RW-1:0]  root_in;
		logic [QW-1:0]  rad_in;
		logic [SBW-1:0] sb_in;
		logic [TW-1:0]  tr;
		logic [TW-1:0]  trial;
		logic           take;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = q;
			assign sb_in   = in_sb;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign sb_in   = sb_s[k-1];
		end

		// bring down the next two radicand bits and try a one in this root bit
		assign tr    = {rem_in, rad_in[QW-1 -: 2]};
		assign trial = TW'({root_in, 2'b01});
		assign take  = (tr >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? RMW'(tr - trial) : RMW'(tr);
				root_s[k] <= {root_in[RW-2:0], take};
				rad_s[k]  <= {rad_in[QW-3:0], 2'b00};
				sb_s[k]   <= sb_in;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_sb    = sb_s[RW-1];

endmodule
`default_nettype wire

// ===== tb/sv/ray_sphere_intersect_tb.sv =====
// Self-checking testbench for the ray/sphere intersection core.
`timescale 1ns / 1ps
module ray_sphere_intersect_tb;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0] uwide_t;

	localparam int ONE = 1 << rsi_pkg::FRAC_BITS;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 700;
	localparam int PAUSE_AT = 350;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 3 * rsi_pkg::COORD_WIDTH + 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rsi_pkg::ray_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsi_pkg::isect_t rsp_data;

	rsi_pkg::ray_t pending_rays[$];
	rsi_pkg::isect_t expected_isects[$];
	int errors = 0;
	int rays_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	ray_sphere_intersect dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic uwide_t floor_sqrt(uwide_t v);
		uwide_t root;
		uwide_t probe;
		root = '0;
		probe = uwide_t'(1) << 254;
		while (probe != 0 && probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic uwide_t root_distance(wide_t n, wide_t a);
		if (n <= 0)
			return '0;
		return (uwide_t'(n) << rsi_pkg::FRAC_BITS) / uwide_t'(a);
	endfunction

	function automatic rsi_pkg::isect_t intersect_ray(rsi_pkg::ray_t r);
		wide_t d[3];
		wide_t oc[3];
		wide_t rad, a, h, k, q;
		uwide_t s, reach;
		rsi_pkg::isect_t res;
		d[0] = r.dir_x;
		d[1] = r.dir_y;
		d[2] = r.dir_z;
		oc[0] = wide_t'(r.origin_x) - wide_t'(r.center_x);
		oc[1] = wide_t'(r.origin_y) - wide_t'(r.center_y);
		oc[2] = wide_t'(r.origin_z) - wide_t'(r.center_z);
		rad = wide_t'({1'b0, r.sphere_radius});
		a = 0;
		h = 0;
		k = 0;
		for (int i = 0; i < 3; i++) begin
			a = a + d[i] * d[i];
			h = h + oc[i] * d[i];
			k = k + oc[i] * oc[i];
		end
		k = k - rad * rad;
		q = h * h - a * k;
		res = '0;
		if (a == 0 || q < 0)
			return res;
		s = floor_sqrt(uwide_t'(q));
		reach = root_distance(-h - wide_t'(s), a);
		if (reach == 0)
			reach = root_distance(-h + wide_t'(s), a);
		if (reach == 0)
			return res;
		res.hit = 1'b1;
		if (reach > uwide_t'({rsi_pkg::DIST_WIDTH{1'b1}}))
			res.distance = '1;
		else
			res.distance = reach[rsi_pkg::DIST_WIDTH-1:0];
		return res;
	endfunction

	function automatic rsi_pkg::ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
			int cx, int cy, int cz, int rad);
		rsi_pkg::ray_t r;
		r.origin_x = ox;
		r.origin_y = oy;
		r.origin_z = oz;
		r.dir_x = dx;
		r.dir_y = dy;
		r.dir_z = dz;
		r.center_x = cx;
		r.center_y = cy;
		r.center_z = cz;
		r.sphere_radius = rad[rsi_pkg::DIST_WIDTH-1:0];
		return r;
	endfunction

	function automatic int scene_coord(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic rsi_pkg::ray_t random_ray();
		rsi_pkg::ray_t r;
		logic [319:0] noise;
		if ($urandom_range(0, 9) < 3) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
			r = noise[$bits(rsi_pkg::ray_t)-1:0];
		end else begin
			r = make_ray(scene_coord(20 * ONE), scene_coord(20 * ONE), scene_coord(20 * ONE),
				scene_coord(4 * ONE), scene_coord(4 * ONE), scene_coord(4 * ONE),
				scene_coord(20 * ONE), scene_coord(20 * ONE), scene_coord(20 * ONE),
				$urandom_range(0, 8 * ONE));
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (rays_sent >= 100 && rays_sent < 250)
			return 0;
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_ray(rsi_pkg::ray_t r);
		pending_rays.insert(pending_rays.size(), r);
	endtask

	// driver: hold the payload until the transfer, then load the next ray
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && !req_ready)) begin
			if (req_valid) begin
				expected_isects.insert(expected_isects.size(), intersect_ray(req_data));
				rays_sent++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_rays.size() > 0 &&
					!(rays_sent == PAUSE_AT && expected_isects.size() > 0)) begin
				req_data <= pending_rays.pop_front();
				req_valid <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the core up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (results_seen >= HOLD_AT && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 2) begin
			hold_left <= $urandom_range(10, 40);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) < 80);
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		rsi_pkg::isect_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (rsp_data.hit)
				hits_seen++;
			if (expected_isects.size() == 0) begin
				$error("unexpected result hit=%0d distance=%0d", rsp_data.hit,
					rsp_data.distance);
				errors++;
			end else begin
				want = expected_isects.pop_front();
				if (rsp_data.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
					errors++;
				end
				if (rsp_data.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance,
						rsp_data.distance);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		// straight hit, origin inside, sphere behind, clean miss
		queue_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 10 * ONE, ONE));
		queue_ray(make_ray(ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE, 2 * ONE));
		queue_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, -10 * ONE, ONE));
		queue_ray(make_ray(0, 0, 0, 0, 0, ONE, 5 * ONE, 0, 10 * ONE, ONE));
		// zero direction
		queue_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 4 * ONE));
		// saturating distance from a tiny direction
		queue_ray(make_ray(0, 0, 0, 0, 0, 1, 0, 0, 100 * ONE, ONE));
		// field extremes
		queue_ray(make_ray('h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff,
			'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff));
		queue_ray(make_ray('h80000000, 'h80000000, 'h80000000, 'h80000000,
			'h80000000, 'h80000000, 'h80000000, 'h80000000, 'h80000000, 'h7fffffff));
		queue_ray(make_ray('h80000000, 'h80000000, 'h80000000, 'h7fffffff,
			'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 0));
		queue_ray(make_ray(0, 0, 0, 1, 1, 1, 0, 0, 0, 'h7fffffff));
		queue_ray(make_ray(-1, -1, -1, -1, -1, -1, 'h80000000, 0, 'h7fffffff,
			'h7fffffff));
		// zero radius on the ray, tangent ray, non-unit direction, origin on the sphere surface
		queue_ray(make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, 0));
		queue_ray(make_ray(0, 0, 0, 0, 0, ONE, ONE, 0, 10 * ONE, ONE));
		queue_ray(make_ray(0, 0, 0, 0, 0, 2 * ONE, 0, 0, 10 * ONE, ONE));
		queue_ray(make_ray(0, 0, 0, 0, 0, -ONE, 0, 0, -3 * ONE, 3 * ONE));
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_ray(random_ray());

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_rays.size() > 0 || req_valid || expected_isects.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d rays against spheres: %0d hits, %0d misses,",
			results_seen, hits_seen, results_seen - hits_seen);
		$display("including edge rays, full-range noise and back-pressure stalls.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
